/* design/pcet_pkg.sv */
// shared constants, codes and helpers for the pointer cell event tracker
package pcet_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS        = 8;
   localparam int MAX_SCREEN       = 8192;
   localparam int MAX_FINGER_TICKS = 5;

   localparam int KIND_W   = 2;
   localparam int DELTA_W  = 24;
   localparam int ABS_W    = 21;
   localparam int CODE_W   = 10;
   localparam int SCROLL_W = 24;
   localparam int SCR_W    = 14;
   localparam int CELL_W   = 8;
   localparam int CELLPOS_W = 14;
   localparam int SUB_W    = 8;
   localparam int ID_W     = 3;
   localparam int PK_W     = 2;
   localparam int CSR_IDX_W = 2;

   // whole pixel index width and stored position width
   localparam int PX_W   = $clog2(MAX_SCREEN);
   localparam int POS_W  = PX_W + FRAC_BITS;
   localparam int CAND_W = DELTA_W + 2;
   // dividend is the whole pixel followed by the sub-cell fraction bits
   localparam int DIV_W  = PX_W + SUB_W;
   localparam int TICK_W = $clog2(MAX_FINGER_TICKS + 1);

   // register reset values
   localparam logic [SCR_W-1:0]  SCREEN_W_RST = SCR_W'(1920);
   localparam logic [SCR_W-1:0]  SCREEN_H_RST = SCR_W'(1080);
   localparam logic [CELL_W-1:0] CELL_W_RST   = CELL_W'(8);
   localparam logic [CELL_W-1:0] CELL_H_RST   = CELL_W'(16);
   localparam logic [POS_W-1:0]  POS_X_RST    = POS_W'((1920 << FRAC_BITS) / 2);
   localparam logic [POS_W-1:0]  POS_Y_RST    = POS_W'((1080 << FRAC_BITS) / 2);

   // scroll thresholds
   localparam logic [SCROLL_W-1:0] WHEEL_THR  = SCROLL_W'(1 << FRAC_BITS);
   localparam logic [SCROLL_W-1:0] FINGER_THR = SCROLL_W'(10 << FRAC_BITS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_W   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_H   = 2'd3;

   // input kinds
   localparam logic [KIND_W-1:0] KIND_REL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ABS    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd3;

   // evdev button codes
   localparam logic [CODE_W-1:0] CODE_LEFT   = 10'h110;
   localparam logic [CODE_W-1:0] CODE_RIGHT  = 10'h111;
   localparam logic [CODE_W-1:0] CODE_MIDDLE = 10'h112;

   // result button ids
   localparam logic [ID_W-1:0] ID_LEFT       = 3'd0;
   localparam logic [ID_W-1:0] ID_RIGHT      = 3'd1;
   localparam logic [ID_W-1:0] ID_MIDDLE     = 3'd2;
   localparam logic [ID_W-1:0] ID_MOVE       = 3'd3;
   localparam logic [ID_W-1:0] ID_WHEEL_UP   = 3'd4;
   localparam logic [ID_W-1:0] ID_WHEEL_DOWN = 3'd5;

   // result press kinds
   localparam logic [PK_W-1:0] PK_PRESS   = 2'd0;
   localparam logic [PK_W-1:0] PK_RELEASE = 2'd1;
   localparam logic [PK_W-1:0] PK_DRAG    = 2'd2;

   // screen size minus one after forcing the register into 1..MAX_SCREEN
   function automatic logic [PX_W-1:0] size_m1(input logic [SCR_W-1:0] r);
      logic [PX_W-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (r > SCR_W'(MAX_SCREEN)) begin
         res = PX_W'(MAX_SCREEN - 1);
      end else begin
         res = PX_W'(r - SCR_W'(1));
      end
      return res;
   endfunction

   // clamp a signed candidate position into 0..hi
   function automatic logic [POS_W-1:0] clamp_pos(input logic [CAND_W-1:0] p,
                                                  input logic [POS_W-1:0] hi);
      logic [POS_W-1:0] res;
      if (p[CAND_W-1]) begin
         res = '0;
      end else if (p > {{(CAND_W-POS_W){1'b0}}, hi}) begin
         res = hi;
      end else begin
         res = p[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

/* design/pcet_serdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
module pcet_serdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pcet_pkg::DIV_W-1:0]       dividend,
   input  logic [pcet_pkg::CELL_W-1:0]      divisor,
   output logic                             busy,
   output logic [pcet_pkg::DIV_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(pcet_pkg::DIV_W);

   logic                           busy_ff, busy_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [pcet_pkg::CELL_W-1:0]    rem_ff, rem_in;
   logic [pcet_pkg::CELL_W-1:0]    dsr_ff, dsr_in;
   logic [pcet_pkg::DIV_W-1:0]     dq_ff, dq_in;
   logic [pcet_pkg::CELL_W:0]      trial;
   logic [pcet_pkg::CELL_W:0]      diff;
   logic                           ge;

   // partial remainder shifted left with the next dividend bit
   assign trial = {rem_ff, dq_ff[pcet_pkg::DIV_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[pcet_pkg::CELL_W-1:0] : trial[pcet_pkg::CELL_W-1:0];
         dq_in  = {dq_ff[pcet_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(pcet_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dq_ff  <= dq_in;
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;

endmodule

/* design/pointer_cell_event_tracker.sv */
// top level: pointer position, text cell tracking and event generation
//
// One item is taken at a time. Relative or absolute motion and left, right or
// middle buttons pass these steps when the cell size is known: the transfer
// cycle clamps the motion position, the load state starts both bit-serial dividers,
// 21 division steps follow (x and y lanes side by side, giving the cell and the
// sub-cell offset from the same division), the end of the division compares
// and the emit state loads the output register. The result becomes valid in
// the cycle in which the next item can be taken. Scroll gives one result per
// step in the scroll state (at most 5), or none when it is below one step.
// Items that give no result free the input in the next cycle (motion with an
// unknown cell size, other buttons) or after the comparison (no cell change).
// The output register holds one result, so the next item is taken while it
// waits for rsp_tready; a further result waits in the engine until it frees.
module pointer_cell_event_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // delta_x, delta_y, abs_x, abs_y, button_code, button_down,
   // scroll_amount, scroll_is_wheel, zero pad
   input  logic [127:0]                        req_tdata,
   // kind
   input  logic [pcet_pkg::KIND_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cell_col, cell_row, sub_x, sub_y, zero pad
   output logic [47:0]                         rsp_tdata,
   // button_id, press_kind
   output logic [4:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [pcet_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcet_pkg::SCR_W-1:0]          csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;

   // input fields
   logic [pcet_pkg::DELTA_W-1:0]  delta_x, delta_y;
   logic [pcet_pkg::ABS_W-1:0]    abs_x, abs_y;
   logic [pcet_pkg::CODE_W-1:0]   button_code;
   logic                          button_down;
   logic [pcet_pkg::SCROLL_W-1:0] scroll_amount;
   logic                          scroll_is_wheel;

   assign delta_x         = req_tdata[23:0];
   assign delta_y         = req_tdata[47:24];
   assign abs_x           = req_tdata[68:48];
   assign abs_y           = req_tdata[89:69];
   assign button_code     = req_tdata[99:90];
   assign button_down     = req_tdata[100];
   assign scroll_amount   = req_tdata[124:101];
   assign scroll_is_wheel = req_tdata[125];

   // configuration
   logic [pcet_pkg::SCR_W-1:0]  screen_w_ff, screen_h_ff;
   logic [pcet_pkg::CELL_W-1:0] cell_w_ff, cell_h_ff;

   // engine state
   logic [2:0]                     state_ff, state_in;
   logic [pcet_pkg::POS_W-1:0]     pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [pcet_pkg::CELLPOS_W-1:0] cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic                           motion_ff, motion_in;
   logic [pcet_pkg::ID_W-1:0]      id_ff, id_in;
   logic [pcet_pkg::PK_W-1:0]      pk_ff, pk_in;
   logic [pcet_pkg::SUB_W-1:0]     sub_x_ff, sub_x_in, sub_y_ff, sub_y_in;
   logic [pcet_pkg::SCROLL_W-1:0]  mag_ff, mag_in;
   logic                           wheel_ff, wheel_in;
   logic [pcet_pkg::TICK_W-1:0]    tick_ff, tick_in;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic [pcet_pkg::ID_W-1:0]      out_id_ff, out_id_in;
   logic [pcet_pkg::PK_W-1:0]      out_pk_ff, out_pk_in;
   logic [pcet_pkg::CELLPOS_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [pcet_pkg::SUB_W-1:0]     out_sx_ff, out_sx_in, out_sy_ff, out_sy_in;
   logic                           out_last_ff, out_last_in;

   // helpers
   logic                           req_xfer;
   logic                           out_free;
   logic                           cell_known;
   logic [pcet_pkg::POS_W-1:0]     hi_x, hi_y;
   logic [pcet_pkg::CAND_W-1:0]    cand_x, cand_y;
   logic [pcet_pkg::SCROLL_W-1:0]  scroll_mag;
   logic [pcet_pkg::SCROLL_W-1:0]  thr, mag_rest;
   logic [pcet_pkg::TICK_W-1:0]    cap;
   logic                           scroll_last;
   logic                           div_start, div_busy_x, div_busy_y;
   logic [pcet_pkg::DIV_W-1:0]     quo_x, quo_y;
   logic [pcet_pkg::CELLPOS_W-1:0] new_col, new_row;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign cell_known = (cell_w_ff != '0) && (cell_h_ff != '0);

   assign hi_x = {pcet_pkg::size_m1(screen_w_ff), {pcet_pkg::FRAC_BITS{1'b0}}};
   assign hi_y = {pcet_pkg::size_m1(screen_h_ff), {pcet_pkg::FRAC_BITS{1'b0}}};

   always_comb begin
      if (req_tuser == pcet_pkg::KIND_REL) begin
         cand_x = {{(pcet_pkg::CAND_W-pcet_pkg::POS_W){1'b0}}, pos_x_ff}
                + {{(pcet_pkg::CAND_W-pcet_pkg::DELTA_W){delta_x[pcet_pkg::DELTA_W-1]}},
                   delta_x};
         cand_y = {{(pcet_pkg::CAND_W-pcet_pkg::POS_W){1'b0}}, pos_y_ff}
                + {{(pcet_pkg::CAND_W-pcet_pkg::DELTA_W){delta_y[pcet_pkg::DELTA_W-1]}},
                   delta_y};
      end else begin
         cand_x = {{(pcet_pkg::CAND_W-pcet_pkg::ABS_W){1'b0}}, abs_x};
         cand_y = {{(pcet_pkg::CAND_W-pcet_pkg::ABS_W){1'b0}}, abs_y};
      end
   end

   // magnitude of the most negative value still fits as unsigned
   assign scroll_mag = scroll_amount[pcet_pkg::SCROLL_W-1] ? (~scroll_amount + 1'b1)
                                                           : scroll_amount;

   assign thr         = wheel_ff ? pcet_pkg::WHEEL_THR : pcet_pkg::FINGER_THR;
   assign cap         = wheel_ff ? pcet_pkg::TICK_W'(1)
                                 : pcet_pkg::TICK_W'(pcet_pkg::MAX_FINGER_TICKS);
   assign mag_rest    = mag_ff - thr;
   assign scroll_last = (mag_rest < thr) || ((tick_ff + pcet_pkg::TICK_W'(1)) == cap);

   assign div_start = (state_ff == ST_LOAD);

   pcet_serdiv u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({pos_x_ff[pcet_pkg::POS_W-1:pcet_pkg::FRAC_BITS],
                  {pcet_pkg::SUB_W{1'b0}}}),
      .divisor  (cell_w_ff),
      .busy     (div_busy_x),
      .quotient (quo_x)
   );

   pcet_serdiv u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({pos_y_ff[pcet_pkg::POS_W-1:pcet_pkg::FRAC_BITS],
                  {pcet_pkg::SUB_W{1'b0}}}),
      .divisor  (cell_h_ff),
      .busy     (div_busy_y),
      .quotient (quo_y)
   );

   // upper quotient bits are the cell, lower bits the fraction of a cell
   assign new_col = {{(pcet_pkg::CELLPOS_W-pcet_pkg::PX_W){1'b0}},
                     quo_x[pcet_pkg::DIV_W-1:pcet_pkg::SUB_W]};
   assign new_row = {{(pcet_pkg::CELLPOS_W-pcet_pkg::PX_W){1'b0}},
                     quo_y[pcet_pkg::DIV_W-1:pcet_pkg::SUB_W]};

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      motion_in    = motion_ff;
      id_in        = id_ff;
      pk_in        = pk_ff;
      sub_x_in     = sub_x_ff;
      sub_y_in     = sub_y_ff;
      mag_in       = mag_ff;
      wheel_in     = wheel_ff;
      tick_in      = tick_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_id_in    = out_id_ff;
      out_pk_in    = out_pk_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_sx_in    = out_sx_ff;
      out_sy_in    = out_sy_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_tuser)
                  pcet_pkg::KIND_REL, pcet_pkg::KIND_ABS: begin
                     if (cell_known) begin
                        pos_x_in  = pcet_pkg::clamp_pos(cand_x, hi_x);
                        pos_y_in  = pcet_pkg::clamp_pos(cand_y, hi_y);
                        motion_in = 1'b1;
                        id_in     = pcet_pkg::ID_MOVE;
                        pk_in     = pcet_pkg::PK_DRAG;
                        state_in  = ST_LOAD;
                     end
                  end
                  pcet_pkg::KIND_BUTTON: begin
                     motion_in = 1'b0;
                     pk_in     = button_down ? pcet_pkg::PK_PRESS : pcet_pkg::PK_RELEASE;
                     sub_x_in  = '0;
                     sub_y_in  = '0;
                     priority if (button_code == pcet_pkg::CODE_LEFT) begin
                        id_in    = pcet_pkg::ID_LEFT;
                        state_in = cell_known ? ST_LOAD : ST_EMIT;
                     end else if (button_code == pcet_pkg::CODE_RIGHT) begin
                        id_in    = pcet_pkg::ID_RIGHT;
                        state_in = cell_known ? ST_LOAD : ST_EMIT;
                     end else if (button_code == pcet_pkg::CODE_MIDDLE) begin
                        id_in    = pcet_pkg::ID_MIDDLE;
                        state_in = cell_known ? ST_LOAD : ST_EMIT;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  pcet_pkg::KIND_SCROLL: begin
                     mag_in   = scroll_mag;
                     wheel_in = scroll_is_wheel;
                     tick_in  = '0;
                     id_in    = scroll_amount[pcet_pkg::SCROLL_W-1] ? pcet_pkg::ID_WHEEL_UP
                                                                    : pcet_pkg::ID_WHEEL_DOWN;
                     state_in = ST_SCROLL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy_x && !div_busy_y) begin
               // offset from centre: fraction minus one half
               sub_x_in = quo_x[pcet_pkg::SUB_W-1:0] ^ {1'b1, {(pcet_pkg::SUB_W-1){1'b0}}};
               sub_y_in = quo_y[pcet_pkg::SUB_W-1:0] ^ {1'b1, {(pcet_pkg::SUB_W-1){1'b0}}};
               if (motion_ff) begin
                  if ((new_col == cur_col_ff) && (new_row == cur_row_ff)) begin
                     state_in = ST_IDLE;
                  end else begin
                     cur_col_in = new_col;
                     cur_row_in = new_row;
                     state_in   = ST_EMIT;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_id_in    = id_ff;
               out_pk_in    = pk_ff;
               out_col_in   = cur_col_ff;
               out_row_in   = cur_row_ff;
               out_sx_in    = sub_x_ff;
               out_sy_in    = sub_y_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            // below one step on entry means no result at all
            if (mag_ff < thr) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_id_in    = id_ff;
               out_pk_in    = pcet_pkg::PK_PRESS;
               out_col_in   = cur_col_ff;
               out_row_in   = cur_row_ff;
               out_sx_in    = '0;
               out_sy_in    = '0;
               out_last_in  = scroll_last;
               mag_in       = mag_rest;
               tick_in      = tick_ff + pcet_pkg::TICK_W'(1);
               if (scroll_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff  <= pcet_pkg::SCREEN_W_RST;
         screen_h_ff  <= pcet_pkg::SCREEN_H_RST;
         cell_w_ff    <= pcet_pkg::CELL_W_RST;
         cell_h_ff    <= pcet_pkg::CELL_H_RST;
         state_ff     <= ST_IDLE;
         pos_x_ff     <= pcet_pkg::POS_X_RST;
         pos_y_ff     <= pcet_pkg::POS_Y_RST;
         cur_col_ff   <= '1;
         cur_row_ff   <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pcet_pkg::CSR_SCREEN_W: screen_w_ff <= csr_wdata;
               pcet_pkg::CSR_SCREEN_H: screen_h_ff <= csr_wdata;
               pcet_pkg::CSR_CELL_W:   cell_w_ff   <= csr_wdata[pcet_pkg::CELL_W-1:0];
               pcet_pkg::CSR_CELL_H:   cell_h_ff   <= csr_wdata[pcet_pkg::CELL_W-1:0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         out_valid_ff <= out_valid_in;
      end
      motion_ff   <= motion_in;
      id_ff       <= id_in;
      pk_ff       <= pk_in;
      sub_x_ff    <= sub_x_in;
      sub_y_ff    <= sub_y_in;
      mag_ff      <= mag_in;
      wheel_ff    <= wheel_in;
      tick_ff     <= tick_in;
      out_id_ff   <= out_id_in;
      out_pk_ff   <= out_pk_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_sx_ff   <= out_sx_in;
      out_sy_ff   <= out_sy_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_sy_ff, out_sx_ff, out_row_ff, out_col_ff};
   assign rsp_tuser  = {out_pk_ff, out_id_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

/* tb/sv/pcet_event_checker.sv */
`timescale 1ns / 1ps
// checker for the pointer cell event tracker: predicts and compares results
module pcet_event_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // delta_x, delta_y, abs_x, abs_y, button_code, button_down,
   // scroll_amount, scroll_is_wheel, zero pad
   input  logic [127:0]                     req_tdata,
   // kind
   input  logic [pcet_pkg::KIND_W-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cell_col, cell_row, sub_x, sub_y, zero pad
   input  logic [47:0]                      rsp_tdata,
   // button_id, press_kind
   input  logic [4:0]                       rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [pcet_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcet_pkg::SCR_W-1:0]       csr_wdata,
   output int                               err_count,
   output int                               pending,
   output int                               checked
);

   typedef struct packed {
      logic [pcet_pkg::ID_W-1:0]      id;
      logic [pcet_pkg::PK_W-1:0]      pk;
      logic [pcet_pkg::CELLPOS_W-1:0] col;
      logic [pcet_pkg::CELLPOS_W-1:0] row;
      logic [pcet_pkg::SUB_W-1:0]     sx;
      logic [pcet_pkg::SUB_W-1:0]     sy;
      logic                           last;
   } pointer_event_type;

   logic [pcet_pkg::SCR_W-1:0]            scr_w, scr_h;
   logic [pcet_pkg::CELL_W-1:0]           cell_w, cell_h;
   logic [pcet_pkg::POS_W-1:0]            pos_x, pos_y;
   logic signed [pcet_pkg::CELLPOS_W-1:0] col_now, row_now;
   pointer_event_type                     pending_events[$];

   initial begin
      err_count = 0;
      pending   = 0;
      checked   = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      err_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // register value forced into 1..MAX_SCREEN
   function automatic int eff_px(input logic [pcet_pkg::SCR_W-1:0] r);
      if (r == '0)
         return 1;
      if (int'(r) > pcet_pkg::MAX_SCREEN)
         return pcet_pkg::MAX_SCREEN;
      return int'(r);
   endfunction

   function automatic logic [pcet_pkg::POS_W-1:0] pin_pos(input longint p, input int size);
      longint top_pos;
      top_pos = longint'(size - 1) << pcet_pkg::FRAC_BITS;
      if (p < 0)
         return '0;
      if (p > top_pos)
         return pcet_pkg::POS_W'(top_pos);
      return pcet_pkg::POS_W'(p);
   endfunction

   // offset of the whole pixel from the cell centre in 1/256 of a cell
   function automatic logic [pcet_pkg::SUB_W-1:0] cell_offset(
         input logic [pcet_pkg::POS_W-1:0] p, input logic [pcet_pkg::CELL_W-1:0] c);
      int px, cv;
      px = int'(p >> pcet_pkg::FRAC_BITS);
      cv = int'(c);
      return pcet_pkg::SUB_W'((px % cv) * 256 / cv - 128);
   endfunction

   task automatic push_event(input logic [pcet_pkg::ID_W-1:0] id,
                             input logic [pcet_pkg::PK_W-1:0] pk,
                             input logic [pcet_pkg::SUB_W-1:0] sx,
                             input logic [pcet_pkg::SUB_W-1:0] sy,
                             input logic last);
      pointer_event_type ev;
      ev.id   = id;
      ev.pk   = pk;
      ev.col  = col_now;
      ev.row  = row_now;
      ev.sx   = sx;
      ev.sy   = sy;
      ev.last = last;
      pending_events.push_back(ev);
   endtask

   task automatic track_pointer_item(input logic [pcet_pkg::KIND_W-1:0] kind,
                                     input logic [127:0] d);
      logic signed [pcet_pkg::DELTA_W-1:0]  dx, dy;
      logic signed [pcet_pkg::SCROLL_W-1:0] sv;
      logic [pcet_pkg::ABS_W-1:0]           ax, ay;
      logic [pcet_pkg::CODE_W-1:0]          code;
      logic                                 down, wheel, hit;
      logic [pcet_pkg::ID_W-1:0]            id;
      logic [pcet_pkg::SUB_W-1:0]           sx, sy;
      longint                               nx, ny, mag, ticks;
      int                                   col, row;
      dx    = d[23:0];
      dy    = d[47:24];
      ax    = d[68:48];
      ay    = d[89:69];
      code  = d[99:90];
      down  = d[100];
      sv    = d[124:101];
      wheel = d[125];
      case (kind)
         pcet_pkg::KIND_REL, pcet_pkg::KIND_ABS: begin
            // unknown cell size: motion is dropped without touching the position
            if (cell_w != '0 && cell_h != '0) begin
               if (kind == pcet_pkg::KIND_REL) begin
                  nx = longint'(pos_x) + longint'(dx);
                  ny = longint'(pos_y) + longint'(dy);
               end else begin
                  nx = longint'(ax);
                  ny = longint'(ay);
               end
               pos_x = pin_pos(nx, eff_px(scr_w));
               pos_y = pin_pos(ny, eff_px(scr_h));
               col = int'(pos_x >> pcet_pkg::FRAC_BITS) / int'(cell_w);
               row = int'(pos_y >> pcet_pkg::FRAC_BITS) / int'(cell_h);
               if (col != int'(col_now) || row != int'(row_now)) begin
                  col_now = pcet_pkg::CELLPOS_W'(col);
                  row_now = pcet_pkg::CELLPOS_W'(row);
                  push_event(pcet_pkg::ID_MOVE, pcet_pkg::PK_DRAG, cell_offset(pos_x, cell_w),
                             cell_offset(pos_y, cell_h), 1'b1);
               end
            end
         end
         pcet_pkg::KIND_BUTTON: begin
            hit = 1'b1;
            id  = pcet_pkg::ID_LEFT;
            case (code)
               pcet_pkg::CODE_LEFT:   id = pcet_pkg::ID_LEFT;
               pcet_pkg::CODE_RIGHT:  id = pcet_pkg::ID_RIGHT;
               pcet_pkg::CODE_MIDDLE: id = pcet_pkg::ID_MIDDLE;
               default:               hit = 1'b0;
            endcase
            if (hit) begin
               sx = '0;
               sy = '0;
               if (cell_w != '0 && cell_h != '0) begin
                  sx = cell_offset(pos_x, cell_w);
                  sy = cell_offset(pos_y, cell_h);
               end
               push_event(id, down ? pcet_pkg::PK_PRESS : pcet_pkg::PK_RELEASE, sx, sy, 1'b1);
            end
         end
         default: begin
            mag = (sv < 0) ? -longint'(sv) : longint'(sv);
            id  = (sv < 0) ? pcet_pkg::ID_WHEEL_UP : pcet_pkg::ID_WHEEL_DOWN;
            if (wheel) begin
               ticks = mag >> pcet_pkg::FRAC_BITS;
               if (ticks > 1)
                  ticks = 1;
            end else begin
               ticks = mag / (longint'(10) << pcet_pkg::FRAC_BITS);
               if (ticks > pcet_pkg::MAX_FINGER_TICKS)
                  ticks = pcet_pkg::MAX_FINGER_TICKS;
            end
            for (longint k = 0; k < ticks; k++)
               push_event(id, pcet_pkg::PK_PRESS, '0, '0, k == ticks - 1);
         end
      endcase
   endtask

   task automatic check_result();
      pointer_event_type got, want;
      got.id   = rsp_tuser[2:0];
      got.pk   = rsp_tuser[4:3];
      got.col  = rsp_tdata[13:0];
      got.row  = rsp_tdata[27:14];
      got.sx   = rsp_tdata[35:28];
      got.sy   = rsp_tdata[43:36];
      got.last = rsp_tlast;
      checked++;
      if (pending_events.size() == 0) begin
         report_mismatch("result with nothing outstanding, button_id", int'(got.id), -1);
      end else begin
         want = pending_events.pop_front();
         if (got.id != want.id)
            report_mismatch("button_id", int'(got.id), int'(want.id));
         if (got.pk != want.pk)
            report_mismatch("press_kind", int'(got.pk), int'(want.pk));
         if (got.col != want.col)
            report_mismatch("cell_col", int'($signed(got.col)), int'($signed(want.col)));
         if (got.row != want.row)
            report_mismatch("cell_row", int'($signed(got.row)), int'($signed(want.row)));
         if (got.sx != want.sx)
            report_mismatch("sub_x", int'($signed(got.sx)), int'($signed(want.sx)));
         if (got.sy != want.sy)
            report_mismatch("sub_y", int'($signed(got.sy)), int'($signed(want.sy)));
         if (got.last != want.last)
            report_mismatch("last", int'(got.last), int'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scr_w   = pcet_pkg::SCR_W'(1920);
         scr_h   = pcet_pkg::SCR_W'(1080);
         cell_w  = pcet_pkg::CELL_W'(8);
         cell_h  = pcet_pkg::CELL_W'(16);
         pos_x   = pcet_pkg::POS_W'((1920 << pcet_pkg::FRAC_BITS) / 2);
         pos_y   = pcet_pkg::POS_W'((1080 << pcet_pkg::FRAC_BITS) / 2);
         col_now = '1;
         row_now = '1;
         pending_events.delete();
      end else begin
         // results belong to older items, so compare before predicting
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (csr_we) begin
            case (csr_index)
               pcet_pkg::CSR_SCREEN_W: scr_w  = csr_wdata;
               pcet_pkg::CSR_SCREEN_H: scr_h  = csr_wdata;
               pcet_pkg::CSR_CELL_W:   cell_w = csr_wdata[pcet_pkg::CELL_W-1:0];
               default:                cell_h = csr_wdata[pcet_pkg::CELL_W-1:0];
            endcase
         end
         if (req_tvalid && req_tready)
            track_pointer_item(req_tuser, req_tdata);
      end
      pending = pending_events.size();
   end

endmodule

/* tb/sv/tb_pointer_cell_event_tracker.sv */
`timescale 1ns / 1ps
// testbench top for the pointer cell event tracker: stimulus and verdict
module tb_pointer_cell_event_tracker;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int DELTA_SPAN   = 40 << pcet_pkg::FRAC_BITS;
   localparam int SCROLL_SPAN  = 64 << pcet_pkg::FRAC_BITS;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [127:0]                   req_tdata  = '0;
   logic [pcet_pkg::KIND_W-1:0]    req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [47:0]                    rsp_tdata;
   logic [4:0]                     rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [pcet_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [pcet_pkg::SCR_W-1:0]     csr_wdata  = '0;

   int err_count, pending, checked;
   int cycles     = 0;
   int items_sent = 0;
   int settings   = 1;
   int burst_left = 0;
   int eff_w      = 1920;
   int eff_h      = 1080;
   bit long_hold  = 1'b0;

   pointer_cell_event_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pcet_event_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .err_count  (err_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: segments of free flow, random stalls and mostly-stalled stretches
   initial begin
      int seg, mode;
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(10, 60);
            repeat (seg) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 5) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic int screen_px(input int r);
      if (r == 0)
         return 1;
      if (r > pcet_pkg::MAX_SCREEN)
         return pcet_pkg::MAX_SCREEN;
      return r;
   endfunction

   function automatic logic [127:0] pack_req(input logic [23:0] dx, input logic [23:0] dy,
                                             input logic [20:0] ax, input logic [20:0] ay,
                                             input logic [9:0] code, input logic down,
                                             input logic [23:0] sv, input logic wheel);
      return {2'b00, wheel, sv, down, code, ay, ax, dy, dx};
   endfunction

   function automatic int random_screen();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return $urandom_range(0, 15);
      if (pick == 1)
         return $urandom_range(pcet_pkg::MAX_SCREEN + 1, (1 << pcet_pkg::SCR_W) - 1);
      return $urandom_range(16, pcet_pkg::MAX_SCREEN);
   endfunction

   function automatic int random_cell();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 0;
      if (pick < 3)
         return $urandom_range(25, 255);
      return $urandom_range(1, 24);
   endfunction

   // one transfer, then either stay in the burst or drop valid for a gap
   task automatic send_item(input logic [pcet_pkg::KIND_W-1:0] kind, input logic [127:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_rel(input logic [23:0] dx, input logic [23:0] dy);
      send_item(pcet_pkg::KIND_REL, pack_req(dx, dy, '0, '0, '0, 1'b0, '0, 1'b0));
   endtask

   task automatic send_abs(input logic [20:0] ax, input logic [20:0] ay);
      send_item(pcet_pkg::KIND_ABS, pack_req('0, '0, ax, ay, '0, 1'b0, '0, 1'b0));
   endtask

   task automatic send_button(input logic [9:0] code, input logic down);
      send_item(pcet_pkg::KIND_BUTTON, pack_req('0, '0, '0, '0, code, down, '0, 1'b0));
   endtask

   task automatic send_scroll(input logic [23:0] sv, input logic wheel);
      send_item(pcet_pkg::KIND_SCROLL, pack_req('0, '0, '0, '0, '0, 1'b0, sv, wheel));
   endtask

   // random content everywhere, then the fields of the chosen kind shaped
   task automatic send_random_item();
      logic [127:0]                d;
      logic [pcet_pkg::KIND_W-1:0] kind;
      int                          pick, mag;
      d    = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         kind = pcet_pkg::KIND_REL;
         if ($urandom_range(0, 6) != 0) begin
            d[23:0]  = 24'(int'($urandom_range(0, 2 * DELTA_SPAN)) - DELTA_SPAN);
            d[47:24] = 24'(int'($urandom_range(0, 2 * DELTA_SPAN)) - DELTA_SPAN);
         end
      end else if (pick < 50) begin
         kind = pcet_pkg::KIND_ABS;
         if ($urandom_range(0, 6) != 0) begin
            d[68:48] = 21'(($urandom_range(0, eff_w + 2) << pcet_pkg::FRAC_BITS)
                           | $urandom_range(0, 255));
            d[89:69] = 21'(($urandom_range(0, eff_h + 2) << pcet_pkg::FRAC_BITS)
                           | $urandom_range(0, 255));
         end
      end else if (pick < 80) begin
         kind = pcet_pkg::KIND_BUTTON;
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 2))
               0:       d[99:90] = pcet_pkg::CODE_LEFT;
               1:       d[99:90] = pcet_pkg::CODE_RIGHT;
               default: d[99:90] = pcet_pkg::CODE_MIDDLE;
            endcase
         end
      end else begin
         kind = pcet_pkg::KIND_SCROLL;
         if ($urandom_range(0, 4) != 0) begin
            mag = $urandom_range(0, SCROLL_SPAN);
            d[124:101] = 24'($urandom_range(0, 1) ? -mag : mag);
         end
      end
      send_item(kind, d);
   endtask

   task automatic run_random(input int n);
      repeat (n) send_random_item();
   endtask

   task automatic write_reg(input logic [pcet_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= pcet_pkg::SCR_W'(value);
      @(posedge clock);
   endtask

   task automatic set_config(input int sw, input int sh, input int cw, input int ch);
      write_reg(pcet_pkg::CSR_SCREEN_W, sw);
      write_reg(pcet_pkg::CSR_SCREEN_H, sh);
      write_reg(pcet_pkg::CSR_CELL_W, cw);
      write_reg(pcet_pkg::CSR_CELL_H, ch);
      csr_we <= 1'b0;
      eff_w = screen_px(sw);
      eff_h = screen_px(sh);
      settings++;
   endtask

   // idle the input, wait for every outstanding result, then cover silent items
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // button with the reset cell size, then motion extremes
      send_button(pcet_pkg::CODE_LEFT, 1'b1);
      send_button(pcet_pkg::CODE_LEFT, 1'b0);
      send_rel(24'h000000, 24'h000000);
      send_rel(24'h000100, 24'h000000);
      send_rel(24'h7FFFFF, 24'h7FFFFF);
      send_rel(24'h800000, 24'h800000);
      send_abs(21'h1FFFFF, 21'h1FFFFF);
      send_abs(21'h000000, 21'h000000);
      send_button(pcet_pkg::CODE_RIGHT, 1'b1);
      send_button(pcet_pkg::CODE_MIDDLE, 1'b1);
      send_button(pcet_pkg::CODE_MIDDLE, 1'b0);
      send_button(pcet_pkg::CODE_RIGHT, 1'b0);
      // codes that are not one of the three buttons
      send_button(10'h000, 1'b1);
      send_button(10'h113, 1'b1);
      send_button(10'h3FF, 1'b0);
      // wheel: below one notch, one notch each way, extremes
      send_scroll(24'h000080, 1'b1);
      send_scroll(24'h000100, 1'b1);
      send_scroll(24'hFFFF00, 1'b1);
      send_scroll(24'h7FFFFF, 1'b1);
      send_scroll(24'h800000, 1'b1);
      // finger: just below and at the threshold, several ticks, capped extremes, zero
      send_scroll(24'h0009FF, 1'b0);
      send_scroll(24'h000A00, 1'b0);
      send_scroll(24'(-25 * 256), 1'b0);
      send_scroll(24'h7FFFFF, 1'b0);
      send_scroll(24'h800000, 1'b0);
      send_scroll(24'h000000, 1'b0);
      settle();

      set_config(pcet_pkg::MAX_SCREEN, pcet_pkg::MAX_SCREEN, 255, 255);
      long_hold = 1'b1;
      run_random(30);
      settle();

      set_config(0, (1 << pcet_pkg::SCR_W) - 1, 1, 1);
      run_random(30);
      settle();

      // unknown cell size
      set_config(1920, 1080, 0, 16);
      run_random(25);
      settle();

      set_config((1 << pcet_pkg::SCR_W) - 1, 0, 16, 0);
      run_random(20);
      settle();

      repeat (5) begin
         set_config(random_screen(), random_screen(), random_cell(), random_cell());
         run_random(30);
         settle();
      end

      $display("run covered %0d input items across %0d register settings",
               items_sent, settings);
      $display("%0d results compared field by field, %0d mismatches", checked, err_count);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
design/pcet_pkg.sv
design/pcet_serdiv.sv
design/pointer_cell_event_tracker.sv
tb/sv/pcet_event_checker.sv
tb/sv/tb_pointer_cell_event_tracker.sv
